// ===== hdl/cartridge_command_frame_decoder_macros.svh =====
// assertion macros for the cartridge command frame decoder
`ifndef CARTRIDGE_COMMAND_FRAME_DECODER_MACROS_SVH
`define CARTRIDGE_COMMAND_FRAME_DECODER_MACROS_SVH

// same-cycle implication, checked outside reset
`define CCFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CCFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ccfd_pkg.sv =====
// types and constants shared by the command frame decoder modules
package ccfd_pkg;

    typedef enum logic [2:0] {
        KIND_MODE_GBA    = 3'd0,
        KIND_MODE_GB     = 3'd1,
        KIND_ROM_READ    = 3'd2,
        KIND_WORD_READ   = 3'd3,
        KIND_WORD_WRITE  = 3'd4,
        KIND_FLASH_WRITE = 3'd5,
        KIND_UNKNOWN     = 3'd6
    } t_kind;

    localparam logic [7:0] OP_MODE_GBA    = 8'd7;
    localparam logic [7:0] OP_MODE_GB     = 8'd8;
    localparam logic [7:0] OP_ROM_READ    = 8'd9;
    localparam logic [7:0] OP_WORD_WRITE  = 8'd10;
    localparam logic [7:0] OP_FLASH_WRITE = 8'd11;
    localparam logic [7:0] OP_WORD_READ   = 8'd12;

    localparam int FRAME_DEPTH = 8;

    typedef struct packed {
        t_kind        kind;
        logic [24:0]  start_addr;
        logic [25:0]  end_addr;
        logic [15:0]  data_word;
        logic [7:0]   flash_kind;
    } t_result;

endpackage

// ===== hdl/ccfd_frame.sv =====
// frame assembly and command decode for one received byte
module ccfd_frame
    import ccfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    output t_result     o_res
);

    logic [2:0] r_count;
    logic [2:0] n_count;
    logic [7:0] r_bytes [FRAME_DEPTH];
    logic [7:0] n_bytes [FRAME_DEPTH];
    logic [3:0] held;
    logic [3:0] frame_len;
    logic       done;
    logic [7:0] op;
    logic [23:0] start_word;
    logic [23:0] end_word;
    logic [24:0] end_plus;

    always_comb begin
        for (int k = 0; k < FRAME_DEPTH; k++) begin
            n_bytes[k] = (r_count == 3'(k)) ? i_rx_byte : r_bytes[k];
        end
    end

    assign op   = n_bytes[0];
    assign held = {1'b0, r_count} + 4'd1;

    always_comb begin
        unique case (op)
            OP_WORD_READ:   frame_len = 4'd4;
            OP_WORD_WRITE:  frame_len = 4'd6;
            OP_ROM_READ:    frame_len = 4'd7;
            OP_FLASH_WRITE: frame_len = 4'd8;
            default:        frame_len = 4'd1;
        endcase
    end

    assign done    = held >= frame_len;
    assign n_count = done ? 3'd0 : held[2:0];

    assign start_word = {n_bytes[3], n_bytes[2], n_bytes[1]};
    assign end_word   = {n_bytes[6], n_bytes[5], n_bytes[4]};
    assign end_plus   = {1'b0, end_word} + 25'd1;

    always_comb begin
        o_res = '0;
        unique case (op)
            OP_MODE_GBA: begin
                o_res.kind = KIND_MODE_GBA;
            end
            OP_MODE_GB: begin
                o_res.kind = KIND_MODE_GB;
            end
            OP_WORD_READ: begin
                o_res.kind       = KIND_WORD_READ;
                o_res.start_addr = {start_word, 1'b0};
            end
            OP_WORD_WRITE: begin
                o_res.kind       = KIND_WORD_WRITE;
                o_res.start_addr = {start_word, 1'b0};
                o_res.data_word  = {n_bytes[5], n_bytes[4]};
            end
            OP_ROM_READ: begin
                o_res.kind       = KIND_ROM_READ;
                o_res.start_addr = {start_word, 1'b0};
                o_res.end_addr   = {end_plus, 1'b0};
            end
            OP_FLASH_WRITE: begin
                o_res.kind       = KIND_FLASH_WRITE;
                o_res.start_addr = {start_word, 1'b0};
                o_res.end_addr   = {end_plus, 1'b0};
                o_res.flash_kind = n_bytes[7];
            end
            default: begin
                o_res.kind = KIND_UNKNOWN;
            end
        endcase
    end

    assign o_res_valid = i_accept && done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 3'd0;
        end else if (i_accept) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_bytes[r_count] <= i_rx_byte;
        end
    end

endmodule

// ===== hdl/ccfd_outq.sv =====
// result register with skid entry
module ccfd_outq
    import ccfd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_res_valid,
    input  t_result  i_res,
    output logic     o_full,
    output logic     o_valid,
    output t_result  o_res,
    input  logic     i_stall
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    take;

    assign take    = r_out_valid && !i_stall;
    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || take) begin
            r_out_valid <= i_res_valid;
        end else if (i_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || take) begin
            r_out <= i_res;
        end else if (i_res_valid) begin
            r_skid <= i_res;
        end
    end

endmodule

// ===== hdl/cartridge_command_frame_decoder.sv =====
// Cartridge command frame decoder, top level. One received byte is taken per
// cycle while o_in_stall is low; the byte that completes a frame has its
// decoded command captured in the result register, or in the skid entry when
// that register is held under output stall. The skid entry keeps o_in_stall
// registered: it rises only when a result is held under output stall and a
// second one is waiting, so bytes keep flowing at one per cycle otherwise.
`include "cartridge_command_frame_decoder_macros.svh"

module cartridge_command_frame_decoder
    import ccfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_command_kind,
    output logic [24:0] o_start_byte_addr,
    output logic [25:0] o_end_byte_addr,
    output logic [15:0] o_data_word,
    output logic [7:0]  o_flash_kind
);

    logic    in_accept;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign in_accept = i_in_valid && !o_in_stall;

    ccfd_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_rx_byte   (i_rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    ccfd_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_full      (o_in_stall),
        .o_valid     (o_out_valid),
        .o_res       (out_res),
        .i_stall     (i_out_stall)
    );

    assign o_command_kind    = out_res.kind;
    assign o_start_byte_addr = out_res.start_addr;
    assign o_end_byte_addr   = out_res.end_addr;
    assign o_data_word       = out_res.data_word;
    assign o_flash_kind      = out_res.flash_kind;

    `CCFD_ASSERT_NOW(a_skid_behind_out, o_in_stall, o_out_valid, "skid full with no result held")
    `CCFD_ASSERT_NEXT(a_result_shows, in_accept && res_valid, o_out_valid, "decoded result lost")
    `CCFD_ASSERT_NOW(a_stall_cause, $rose(o_in_stall), $past(o_out_valid && i_out_stall), "stall without held result")
    `CCFD_ASSERT_NOW(a_kind_range, o_out_valid, o_command_kind != 3'd7, "command kind out of range")

endmodule

// ===== sim/cartridge_command_frame_decoder_tb.sv =====
// testbench for the cartridge command frame decoder, checked transfer by transfer
module cartridge_command_frame_decoder_tb
    import ccfd_pkg::*;
();

    localparam int TOTAL_BYTES = 1850;
    localparam int PHASE_LEN   = 150;
    localparam int DRAIN_GAP   = 20;

    typedef enum int {PH_FREE, PH_SENDER_IDLE, PH_RECEIVER_STALL, PH_BOTH} t_idle_phase;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_rx_byte   = 8'h00;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [2:0]  o_command_kind;
    logic [24:0] o_start_byte_addr;
    logic [25:0] o_end_byte_addr;
    logic [15:0] o_data_word;
    logic [7:0]  o_flash_kind;

    logic [7:0]  byte_queue[$];
    t_result     pending_commands[$];
    logic [7:0]  frame_buf[FRAME_DEPTH];
    int          frame_fill     = 0;
    int          bytes_taken    = 0;
    int          mismatch_count = 0;
    int          idle_pct;
    int          stall_pct;
    t_idle_phase idle_phase;

    cartridge_command_frame_decoder u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_rx_byte         (i_rx_byte),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_command_kind    (o_command_kind),
        .o_start_byte_addr (o_start_byte_addr),
        .o_end_byte_addr   (o_end_byte_addr),
        .o_data_word       (o_data_word),
        .o_flash_kind      (o_flash_kind)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always_comb begin
        idle_phase = t_idle_phase'((bytes_taken / PHASE_LEN) % 4);
        idle_pct   = 0;
        stall_pct  = 0;
        case (idle_phase)
            PH_SENDER_IDLE: idle_pct = 65;
            PH_RECEIVER_STALL: stall_pct = 65;
            PH_BOTH: begin
                idle_pct  = 32;
                stall_pct = 32;
            end
            default: ;
        endcase
    end

    function automatic int frame_len(input logic [7:0] op);
        case (op)
            OP_WORD_READ:   return 4;
            OP_WORD_WRITE:  return 6;
            OP_ROM_READ:    return 7;
            OP_FLASH_WRITE: return 8;
            default:        return 1;
        endcase
    endfunction

    function automatic logic [23:0] word_addr(input int first);
        return {frame_buf[first + 2], frame_buf[first + 1], frame_buf[first]};
    endfunction

    task automatic decode_rx_byte(input logic [7:0] rx);
        t_result    cmd;
        logic [7:0] op;
        frame_buf[frame_fill] = rx;
        frame_fill++;
        op = frame_buf[0];
        if (frame_fill < frame_len(op)) return;
        frame_fill = 0;
        cmd = '0;
        case (op)
            OP_MODE_GBA: cmd.kind = KIND_MODE_GBA;
            OP_MODE_GB: cmd.kind = KIND_MODE_GB;
            OP_WORD_READ: begin
                cmd.kind       = KIND_WORD_READ;
                cmd.start_addr = {word_addr(1), 1'b0};
            end
            OP_WORD_WRITE: begin
                cmd.kind       = KIND_WORD_WRITE;
                cmd.start_addr = {word_addr(1), 1'b0};
                cmd.data_word  = {frame_buf[5], frame_buf[4]};
            end
            OP_ROM_READ: begin
                cmd.kind       = KIND_ROM_READ;
                cmd.start_addr = {word_addr(1), 1'b0};
                cmd.end_addr   = {25'(word_addr(4)) + 25'd1, 1'b0};
            end
            OP_FLASH_WRITE: begin
                cmd.kind       = KIND_FLASH_WRITE;
                cmd.start_addr = {word_addr(1), 1'b0};
                cmd.end_addr   = {25'(word_addr(4)) + 25'd1, 1'b0};
                cmd.flash_kind = frame_buf[7];
            end
            default: cmd.kind = KIND_UNKNOWN;
        endcase
        pending_commands.push_back(cmd);
    endtask

    function automatic void check_field(input string name, input logic [25:0] want,
                                        input logic [25:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t %s expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    // byte driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) begin
                decode_rx_byte(i_rx_byte);
                bytes_taken <= bytes_taken + 1;
            end
            if (byte_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
                i_rx_byte  <= byte_queue.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // command monitor
    always @(posedge i_clk) begin : command_monitor
        t_result want;
        i_out_stall <= i_rst_n && ($urandom_range(99) < stall_pct);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_commands.size() == 0) begin
                mismatch_count++;
                $display("%0t unexpected transfer: expected none, actual kind %0d",
                         $time, o_command_kind);
            end else begin
                want = pending_commands.pop_front();
                check_field("command_kind", 26'(want.kind), 26'(o_command_kind));
                check_field("start_byte_addr", 26'(want.start_addr),
                            26'(o_start_byte_addr));
                check_field("end_byte_addr", want.end_addr, o_end_byte_addr);
                check_field("data_word", 26'(want.data_word), 26'(o_data_word));
                check_field("flash_kind", 26'(want.flash_kind), 26'(o_flash_kind));
            end
        end
    end

    initial begin
        int         total;
        int         pick;
        logic [7:0] op;
        // modes, unknown extremes, then each argument command with extreme fields
        byte_queue = {OP_MODE_GBA, OP_MODE_GB, 8'h00, 8'hff,
                      OP_WORD_READ, 8'h00, 8'h00, 8'h00,
                      OP_WORD_WRITE, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                      OP_ROM_READ, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff,
                      OP_FLASH_WRITE, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'hff};
        while (byte_queue.size() < TOTAL_BYTES) begin
            if ($urandom_range(99) < 80) begin
                case ($urandom_range(5))
                    0: op = OP_MODE_GBA;
                    1: op = OP_MODE_GB;
                    2: op = OP_WORD_READ;
                    3: op = OP_WORD_WRITE;
                    4: op = OP_ROM_READ;
                    default: op = OP_FLASH_WRITE;
                endcase
            end else begin
                op = 8'($urandom);
            end
            byte_queue.push_back(op);
            repeat (frame_len(op) - 1) begin
                pick = $urandom_range(7);
                byte_queue.push_back(pick == 0 ? 8'h00 : pick == 1 ? 8'hff : 8'($urandom));
            end
        end
        total = byte_queue.size();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (bytes_taken != total) @(posedge i_clk);
        while (pending_commands.size() != 0) @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #1_600_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
